// ===== rtl/vkhs_pkg.sv =====
`default_nettype none

package vkhs_pkg;

    // widths of the key parts
    localparam int PATH_W   = 32;
    localparam int KIND_W   = 16;
    localparam int DEVICE_W = 32;
    localparam int KEY_W    = PATH_W + KIND_W + DEVICE_W;

    // one input item: the key to look up and insert
    typedef struct packed {
        logic [PATH_W-1:0]   key_path;
        logic [KIND_W-1:0]   key_kind;
        logic [DEVICE_W-1:0] key_device;
    } vkhs_key_t;

    // one result item
    typedef struct packed {
        logic already_seen;
        logic bucket_full;
    } vkhs_res_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REM,
        ST_LOOK,
        ST_CNT,
        ST_SEARCH
    } vkhs_state_t;

endpackage

`default_nettype wire

// ===== rtl/vkhs_ram.sv =====
`default_nettype none

module vkhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/visited_key_hash_set.sv =====
`default_nettype none
// Visited-key hash set: insert-if-absent over bucketed storage.
// Input channel: drive key and pulse start; the item is taken at a rising
// edge where start is high and busy is low. busy stays high while the item
// is worked on. Output channel: done is high for exactly one cycle with the
// result on result; the receiver cannot stall it, so it must take it then.
// The bucket is key_path modulo BUCKETS (low bits for a power of two,
// otherwise a reciprocal multiply, a back-multiply and one correcting
// subtract).
// The search reads the n keys already held in the bucket (n is at most
// BUCKET_DEPTH) in order; a hit ends at the matching entry. The key store
// has one read port and the search compares one stored entry per cycle.
// A new item can be taken in the cycle done is shown.
// After reset the block runs a clearing pass over the bucket counts, one
// bucket per cycle, with busy high; stored keys need no clearing since
// only the first n entries of a bucket are ever read.
// A new key whose bucket is full is dropped and flagged with bucket_full.

module visited_key_hash_set
    import vkhs_pkg::*;
#(
    parameter int BUCKETS      = 128,
    parameter int BUCKET_DEPTH = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire vkhs_key_t key,
    output logic           done,
    output vkhs_res_t      result
);

    localparam int  BW    = $clog2(BUCKETS);
    localparam int  CW    = $clog2(BUCKET_DEPTH + 1);
    localparam int  KAW   = $clog2(BUCKETS * BUCKET_DEPTH);
    localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [PATH_W-1:0] RECIP = PATH_W'((64'd1 << PATH_W) / 64'(BUCKETS));

    vkhs_state_t     state_reg, state_next;
    vkhs_key_t       key_reg, key_next;
    logic [PATH_W-1:0] quot_reg, quot_next;
    logic [BW:0]     part_reg, part_next;
    logic [1:0]      step_reg, step_next;
    logic [BW-1:0]   rem_reg, rem_next;
    logic [BW-1:0]   clr_reg, clr_next;
    logic [KAW-1:0]  base_reg, base_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            done_reg, done_next;
    vkhs_res_t       res_reg, res_next;

    logic [BW-1:0]   bucket;
    logic [2*PATH_W-1:0] recip_prod;
    logic [PATH_W-1:0] quot_back;
    logic            last;
    logic            hit;

    // bucket count memory controls
    logic            cnt_we;
    logic [BW-1:0]   cnt_waddr;
    logic [CW-1:0]   cnt_wdata;
    logic            cnt_re;
    logic [CW-1:0]   cnt_rdata;

    // key memory controls
    logic            kv_we;
    logic [KAW-1:0]  kv_waddr;
    logic            kv_re;
    logic [KAW-1:0]  kv_raddr;
    vkhs_key_t       kv_rdata;

    assign bucket     = POW2 ? key_reg.key_path[BW-1:0] : rem_reg;
    assign recip_prod = (2*PATH_W)'(key_reg.key_path) * (2*PATH_W)'(RECIP);
    assign quot_back  = PATH_W'(quot_reg * PATH_W'(BUCKETS));
    assign last       = ((CW+1)'(idx_reg) + (CW+1)'(1)) >= (CW+1)'(cnt_reg);
    assign hit        = (idx_reg < cnt_reg) && (kv_rdata == key_reg);

    vkhs_ram #(
        .WIDTH (CW),
        .DEPTH (BUCKETS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (bucket),
        .rdata (cnt_rdata)
    );

    vkhs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (BUCKETS * BUCKET_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (key_reg),
        .re    (kv_re),
        .raddr (kv_raddr),
        .rdata (kv_rdata)
    );

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        quot_reg  <= quot_next;
        part_reg  <= part_next;
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        base_reg  <= base_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    // sequencer: next state, datapath updates and memory controls
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        quot_next  = quot_reg;
        part_next  = part_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        clr_next   = clr_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = bucket;
        cnt_wdata  = cnt_reg + CW'(1);
        cnt_re     = 1'b0;
        kv_we      = 1'b0;
        kv_waddr   = base_reg + KAW'(cnt_reg);
        kv_re      = 1'b0;
        kv_raddr   = base_reg + KAW'(idx_reg) + KAW'(1);

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one bucket count per cycle
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = POW2 ? ST_LOOK : ST_REM;
                end
            end

            ST_REM:
            begin
                // quotient estimate by reciprocal, back-multiply, one correction
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd0)
                begin
                    quot_next = recip_prod[2*PATH_W-1:PATH_W];
                end
                else if (step_reg == 2'd1)
                begin
                    part_next = (BW+1)'(key_reg.key_path - quot_back);
                end
                else
                begin
                    if (part_reg >= (BW+1)'(BUCKETS))
                    begin
                        rem_next = BW'(part_reg - (BW+1)'(BUCKETS));
                    end
                    else
                    begin
                        rem_next = BW'(part_reg);
                    end
                    state_next = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                // read bucket count, form bucket base address
                cnt_re     = 1'b1;
                base_next  = KAW'(bucket) * KAW'(BUCKET_DEPTH);
                state_next = ST_CNT;
            end

            ST_CNT:
            begin
                // count arrives; fetch first entry of a non-empty bucket
                cnt_next   = cnt_rdata;
                idx_next   = '0;
                kv_re      = (cnt_rdata != '0);
                kv_raddr   = base_reg;
                state_next = ST_SEARCH;
            end

            ST_SEARCH:
            begin
                // compare one stored entry per cycle, prefetch the next
                if (hit)
                begin
                    res_next.already_seen = 1'b1;
                    res_next.bucket_full  = 1'b0;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
                else if (last)
                begin
                    res_next.already_seen = 1'b0;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                    if (cnt_reg == CW'(BUCKET_DEPTH))
                    begin
                        res_next.bucket_full = 1'b1;
                    end
                    else
                    begin
                        res_next.bucket_full = 1'b0;
                        kv_we                = 1'b1;
                        cnt_we               = 1'b1;
                    end
                end
                else
                begin
                    kv_re    = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/vkhs_checker.sv =====
`default_nettype none

module vkhs_checker
    import vkhs_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire vkhs_res_t result
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // no result in the cycle right after an accept
    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result came too early after accept");

    // a result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // the block is ready when it shows a result
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while showing a result");

    // a full bucket is only reported for a new key
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.already_seen && result.bucket_full))
        else $error("key reported both seen and dropped");

endmodule

bind visited_key_hash_set vkhs_checker u_vkhs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import vkhs_pkg::*;

    localparam int NUM_BUCKETS  = 128;
    localparam int SLOTS        = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 1080;
    localparam int POOL_MAX     = 256;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    vkhs_key_t key;
    logic      done;
    vkhs_res_t result;

    // predicts lookup outcomes and checks them in order
    class seen_set_scoreboard;
        int unsigned         fill[NUM_BUCKETS];
        logic [PATH_W-1:0]   path_tab[NUM_BUCKETS][SLOTS];
        logic [KIND_W-1:0]   kind_tab[NUM_BUCKETS][SLOTS];
        logic [DEVICE_W-1:0] device_tab[NUM_BUCKETS][SLOTS];
        vkhs_res_t           outcome_q[$];
        int unsigned         errors;

        function new();
            foreach (fill[i])
                fill[i] = 0;
            errors = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function int unsigned pending();
            return outcome_q.size();
        endfunction

        // insert-if-absent on the shadow set, queue the outcome
        function void note_key(vkhs_key_t k);
            int unsigned b;
            vkhs_res_t   r;
            bit          hit;
            b   = k.key_path % NUM_BUCKETS;
            hit = 0;
            for (int i = 0; i < fill[b]; i++)
            begin
                if (path_tab[b][i] == k.key_path && kind_tab[b][i] == k.key_kind &&
                    device_tab[b][i] == k.key_device)
                    hit = 1;
            end
            r.already_seen = hit;
            r.bucket_full  = 0;
            if (!hit)
            begin
                if (fill[b] >= SLOTS)
                    r.bucket_full = 1;
                else
                begin
                    path_tab[b][fill[b]]   = k.key_path;
                    kind_tab[b][fill[b]]   = k.key_kind;
                    device_tab[b][fill[b]] = k.key_device;
                    fill[b]++;
                end
            end
            outcome_q.push_back(r);
        endfunction

        task check_outcome(vkhs_res_t got);
            vkhs_res_t want;
            if (outcome_q.size() == 0)
                report("result with no item outstanding");
            else
            begin
                want = outcome_q.pop_front();
                if (got.already_seen !== want.already_seen)
                    report($sformatf("already_seen %b, expected %b",
                                     got.already_seen, want.already_seen));
                if (got.bucket_full !== want.bucket_full)
                    report($sformatf("bucket_full %b, expected %b",
                                     got.bucket_full, want.bucket_full));
            end
        endtask
    endclass

    seen_set_scoreboard sb;
    vkhs_key_t          key_pool[$];
    int unsigned        stall_cycles;

    visited_key_hash_set #(
        .BUCKETS      (NUM_BUCKETS),
        .BUCKET_DEPTH (SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .key    (key),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watch accepted items and results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_key(key);
            if (done)
                sb.check_outcome(result);
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic vkhs_key_t make_key(logic [PATH_W-1:0] p, logic [KIND_W-1:0] k,
                                           logic [DEVICE_W-1:0] d);
        vkhs_key_t r;
        r.key_path   = p;
        r.key_kind   = k;
        r.key_device = d;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // random item: repeats, near misses, keys aimed at a few hot buckets, noise
    function automatic vkhs_key_t next_random_key();
        int                 r;
        int                 bit_idx;
        logic [KEY_W-1:0]   flat;
        logic [6:0]         hot;
        r   = $urandom_range(0, 99);
        hot = 7'(3 + 37 * $urandom_range(0, 5));
        if (r < 35 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 47 && key_pool.size() > 0)
        begin
            flat    = key_pool[$urandom_range(0, key_pool.size() - 1)];
            bit_idx = $urandom_range(0, KEY_W - 1);
            flat[bit_idx] = ~flat[bit_idx];
            return vkhs_key_t'(flat);
        end
        if (r < 77)
            return make_key({25'($urandom), hot}, 16'($urandom_range(0, 3)),
                            32'($urandom_range(0, 3)));
        if (r < 95)
            return make_key($urandom, 16'($urandom), $urandom);
        return make_key($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0,
                        $urandom_range(0, 1) ? '1 : '0);
    endfunction

    // present one item and hold it until taken
    task send_key(vkhs_key_t k);
        start <= 1'b1;
        key   <= k;
        do
            @(posedge clk);
        while (busy);
        key_pool.push_back(k);
        if (key_pool.size() > POOL_MAX)
            void'(key_pool.pop_front());
    endtask

    // idle the input side with junk on the key
    task pause(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            key   <= make_key($urandom, 16'($urandom), $urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // main sequence
    initial
    begin
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        key   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, plain hit, same path with other kind or device
        send_key(make_key('0, '0, '0));
        pause(pick_gap());
        send_key(make_key('1, '1, '1));
        send_key(make_key('1, '1, '1));
        pause(pick_gap());
        send_key(make_key('1, '0, '1));
        send_key(make_key('1, '1, '0));
        send_key(make_key('0, '0, '0));

        // fill one bucket, then overflow, hit on last slot, dropped key again
        for (int i = 0; i < SLOTS; i++)
        begin
            send_key(make_key({25'(i * 4099), 7'h2a}, 16'(i), 32'hffff_0000 + i));
            pause(pick_gap());
        end
        send_key(make_key({25'h1ff_ffff, 7'h2a}, '1, '1));
        send_key(make_key({25'((SLOTS - 1) * 4099), 7'h2a}, 16'(SLOTS - 1),
                          32'hffff_0000 + SLOTS - 1));
        pause(pick_gap());
        send_key(make_key({25'h1ff_ffff, 7'h2a}, '1, '1));

        // random items, with stretches of back-to-back traffic
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_key(next_random_key());
            if ((n / 64) % 4 == 1)
                pause(0);
            else
                pause(pick_gap());
        end
        pause(1);

        // drain
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
